@@ rtl/ccrf_pkg.sv @@
// Shared types and constants for the capped contact repulsion force block.
// No dependencies; every other file in rtl imports this package.
package ccrf_pkg;

    // Fixed point format of lengths, volumes and forces
    localparam int FRAC_BITS = 16;
    localparam int SHIFT     = 2 * FRAC_BITS;

    // Widths of the force product Kn * vol * p * |c| and its shifted numerator
    localparam int PROD_W = 127;
    localparam int NUM_W  = PROD_W - SHIFT;
    localparam int HI_W   = NUM_W - 32;

    // Pipeline depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_LAW    = 2'd0;
    localparam logic [1:0] CFG_STIFF  = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    // Contact law codes
    localparam logic [1:0] LAW_NONE   = 2'd0;
    localparam logic [1:0] LAW_BROKEN = 2'd1;
    localparam logic [1:0] LAW_GAP    = 2'd2;

    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic        [31:0] volume;
        logic        [30:0] ref_length;
    } item_word_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               saturated;
    } result_word_t;

    // Work handed to the divider: numerator split into remainder seed and low bits
    typedef struct packed {
        logic             kill;
        logic [2:0]       neg;
        logic [2:0]       ovf;
        logic [30:0]      r;
        logic [2:0][30:0] rem;
        logic [2:0][31:0] num_lo;
    } div_word_t;

endpackage

@@ rtl/ccrf_square.sv @@
// Squares of the component magnitudes and their sum, two register stages.
// Depends on ccrf_pkg.
module ccrf_square (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  ccrf_pkg::item_word_t in_word,
    output logic                out_valid,
    output ccrf_pkg::item_word_t out_word,
    output logic [63:0]         out_sum
);
    import ccrf_pkg::*;

    logic [2:0][31:0] mag;
    logic [2:0][63:0] sq_reg;
    logic             sq_valid_reg;
    item_word_t       sq_word_reg;
    logic             sum_valid_reg;
    item_word_t       sum_word_reg;
    logic [63:0]      sum_reg;

    // magnitudes; the most negative value maps to 2^31
    always_comb
    begin
        mag[0] = in_word.rel_x[31] ? (~in_word.rel_x + 32'd1) : in_word.rel_x;
        mag[1] = in_word.rel_y[31] ? (~in_word.rel_y + 32'd1) : in_word.rel_y;
        mag[2] = in_word.rel_z[31] ? (~in_word.rel_z + 32'd1) : in_word.rel_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // squares, then the sum (below 2^64 as each square is at most 2^62)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0]    <= mag[0] * mag[0];
            sq_reg[1]    <= mag[1] * mag[1];
            sq_reg[2]    <= mag[2] * mag[2];
            sq_word_reg  <= in_word;
            sum_reg      <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sum_word_reg <= sq_word_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_word  = sum_word_reg;
    assign out_sum   = sum_reg;

endmodule

@@ rtl/ccrf_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on ccrf_pkg.
module ccrf_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  ccrf_pkg::item_word_t in_word,
    input  logic [63:0]          in_sum,
    output logic                 out_valid,
    output ccrf_pkg::item_word_t out_word,
    output logic [31:0]          out_root
);
    import ccrf_pkg::*;

    logic       st_valid [0:SQRT_STAGES];
    item_word_t st_word  [0:SQRT_STAGES];
    logic [63:0] st_rad  [0:SQRT_STAGES];
    logic [32:0] st_rem  [0:SQRT_STAGES];
    logic [31:0] st_root [0:SQRT_STAGES];

    assign st_valid[0] = in_valid;
    assign st_word[0]  = in_word;
    assign st_rad[0]   = in_sum;
    assign st_rem[0]   = 33'd0;
    assign st_root[0]  = 32'd0;

    genvar s;
    generate
        for (s = 0; s < SQRT_STAGES; s++)
        begin : g_stage
            logic        valid_reg;
            item_word_t  word_reg;
            logic [63:0] rad_reg;
            logic [32:0] rem_reg;
            logic [31:0] root_reg;
            logic [34:0] rem_sh;
            logic [34:0] trial;
            logic        take;
            logic [34:0] rem_sub;

            // bring down two radicand bits and try root*4+1
            always_comb
            begin
                rem_sh  = {st_rem[s], st_rad[s][63:62]};
                trial   = {1'b0, st_root[s], 2'b01};
                take    = (rem_sh >= trial);
                rem_sub = rem_sh - trial;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg <= 1'b0;
                else if (adv)
                    valid_reg <= st_valid[s];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    word_reg <= st_word[s];
                    rad_reg  <= {st_rad[s][61:0], 2'b00};
                    rem_reg  <= take ? rem_sub[32:0] : rem_sh[32:0];
                    root_reg <= {st_root[s][30:0], take};
                end
            end

            assign st_valid[s+1] = valid_reg;
            assign st_word[s+1]  = word_reg;
            assign st_rad[s+1]   = rad_reg;
            assign st_rem[s+1]   = rem_reg;
            assign st_root[s+1]  = root_reg;
        end
    endgenerate

    assign out_valid = st_valid[SQRT_STAGES];
    assign out_word  = st_word[SQRT_STAGES];
    assign out_root  = st_root[SQRT_STAGES];

endmodule

@@ rtl/ccrf_force.sv @@
// Contact law, penetration and the wide force product, six register stages.
// Depends on ccrf_pkg; feeds ccrf_divide.
module ccrf_force (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  ccrf_pkg::item_word_t in_word,
    input  logic [31:0]          in_root,
    input  logic [1:0]           law,
    input  logic [31:0]          stiffness,
    input  logic [30:0]          contact_radius,
    output logic                 out_valid,
    output ccrf_pkg::div_word_t  out_word
);
    import ccrf_pkg::*;

    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             active;
    logic [30:0]      natural;
    logic [30:0]      p_raw;
    logic [30:0]      cap;
    logic [30:0]      p_sel;
    logic             kill;

    // stage L
    logic             l_valid_reg, l_kill_reg;
    logic [63:0]      l_kv_reg;
    logic [30:0]      l_p_reg, l_r_reg;
    logic [2:0][31:0] l_mag_reg;
    logic [2:0]       l_neg_reg;
    // stage A
    logic             a_valid_reg, a_kill_reg;
    logic [62:0]      a_lo_reg, a_hi_reg;
    logic [30:0]      a_r_reg;
    logic [2:0][31:0] a_mag_reg;
    logic [2:0]       a_neg_reg;
    // stage B
    logic             b_valid_reg, b_kill_reg;
    logic [94:0]      b_kvp_reg;
    logic [30:0]      b_r_reg;
    logic [2:0][31:0] b_mag_reg;
    logic [2:0]       b_neg_reg;
    // stage C
    logic             c_valid_reg, c_kill_reg;
    logic [2:0][63:0] c_pp0_reg, c_pp1_reg;
    logic [2:0][62:0] c_pp2_reg;
    logic [30:0]      c_r_reg;
    logic [2:0]       c_neg_reg;
    // stage D
    logic                    d_valid_reg, d_kill_reg;
    logic [2:0][PROD_W-1:0]  d_full_reg;
    logic [30:0]             d_r_reg;
    logic [2:0]              d_neg_reg;
    // stage E
    logic                    e_valid_reg;
    div_word_t               e_word_reg;
    div_word_t               e_next;
    logic [2:0][NUM_W-1:0]   num;
    logic [2:0][HI_W-1:0]    num_hi;

    // magnitudes and signs of the components
    always_comb
    begin
        mag[0] = in_word.rel_x[31] ? (~in_word.rel_x + 32'd1) : in_word.rel_x;
        mag[1] = in_word.rel_y[31] ? (~in_word.rel_y + 32'd1) : in_word.rel_y;
        mag[2] = in_word.rel_z[31] ? (~in_word.rel_z + 32'd1) : in_word.rel_z;
        neg    = {in_word.rel_z[31], in_word.rel_y[31], in_word.rel_x[31]};
    end

    // natural length from the law, penetration capped at a quarter of it
    always_comb
    begin
        active  = 1'b0;
        natural = 31'd0;
        case (law)
            LAW_BROKEN:
            begin
                active  = 1'b1;
                natural = contact_radius;
            end
            LAW_GAP:
            begin
                if ((contact_radius != 31'd0) && (in_root < {1'b0, contact_radius}))
                begin
                    active  = 1'b1;
                    natural = (in_word.ref_length != 31'd0) ? in_word.ref_length
                                                            : contact_radius;
                end
            end
            default:
            begin
                active  = 1'b0;
                natural = 31'd0;
            end
        endcase
        p_raw = natural - in_root[30:0];
        cap   = {2'b00, natural[30:2]};
        p_sel = (p_raw > cap) ? cap : p_raw;
        kill  = !active || (in_root == 32'd0) || (natural == 31'd0) ||
                (in_root >= {1'b0, natural}) || (p_sel == 31'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            l_valid_reg <= in_valid;
            a_valid_reg <= l_valid_reg;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // numerator split for the divider; overflow when the high part reaches R
    always_comb
    begin
        e_next.kill = d_kill_reg;
        e_next.neg  = d_neg_reg;
        e_next.r    = d_r_reg;
        for (int i = 0; i < 3; i++)
        begin
            num[i]          = d_full_reg[i][PROD_W-1:SHIFT];
            num_hi[i]       = num[i][NUM_W-1:32];
            e_next.ovf[i]   = (num_hi[i] >= HI_W'(d_r_reg));
            e_next.rem[i]   = num_hi[i][30:0];
            e_next.num_lo[i] = num[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // L: law and Kn * vol
            l_kill_reg <= kill;
            l_kv_reg   <= stiffness * in_word.volume;
            l_p_reg    <= p_sel;
            l_r_reg    <= in_root[30:0];
            l_mag_reg  <= mag;
            l_neg_reg  <= neg;
            // A: two partial products of (Kn * vol) * p
            a_kill_reg <= l_kill_reg;
            a_lo_reg   <= l_kv_reg[31:0] * l_p_reg;
            a_hi_reg   <= l_kv_reg[63:32] * l_p_reg;
            a_r_reg    <= l_r_reg;
            a_mag_reg  <= l_mag_reg;
            a_neg_reg  <= l_neg_reg;
            // B: join them
            b_kill_reg <= a_kill_reg;
            b_kvp_reg  <= {a_hi_reg, 32'd0} + {32'd0, a_lo_reg};
            b_r_reg    <= a_r_reg;
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            // C: three partial products per component
            c_kill_reg <= b_kill_reg;
            c_r_reg    <= b_r_reg;
            c_neg_reg  <= b_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                c_pp0_reg[i] <= b_kvp_reg[31:0] * b_mag_reg[i];
                c_pp1_reg[i] <= b_kvp_reg[63:32] * b_mag_reg[i];
                c_pp2_reg[i] <= b_kvp_reg[94:64] * b_mag_reg[i];
            end
            // D: full product
            d_kill_reg <= c_kill_reg;
            d_r_reg    <= c_r_reg;
            d_neg_reg  <= c_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_full_reg[i] <= PROD_W'(c_pp0_reg[i]) +
                                 {PROD_W'(c_pp1_reg[i]) << 32} +
                                 {PROD_W'(c_pp2_reg[i]) << 64};
            end
            // E: shift and overflow check
            e_word_reg <= e_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_word  = e_word_reg;

endmodule

@@ rtl/ccrf_divide.sv @@
// Restoring divider, one quotient bit per stage, three lanes, then saturation.
// Depends on ccrf_pkg.
module ccrf_divide (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  ccrf_pkg::div_word_t    in_word,
    output logic                   out_valid,
    output ccrf_pkg::result_word_t out_word
);
    import ccrf_pkg::*;

    logic      st_valid [0:DIV_STAGES];
    div_word_t st_word  [0:DIV_STAGES];

    assign st_valid[0] = in_valid;
    assign st_word[0]  = in_word;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic      valid_reg;
            div_word_t word_reg;
            div_word_t word_next;
            logic [2:0][31:0] trial;
            logic [2:0][31:0] diff;
            logic [2:0]       take;

            // shift in the next numerator bit; quotient bit enters the low end
            always_comb
            begin
                word_next = st_word[s];
                for (int i = 0; i < 3; i++)
                begin
                    trial[i] = {st_word[s].rem[i], st_word[s].num_lo[i][31]};
                    take[i]  = (trial[i] >= {1'b0, st_word[s].r});
                    diff[i]  = trial[i] - {1'b0, st_word[s].r};
                    word_next.rem[i]    = take[i] ? diff[i][30:0] : trial[i][30:0];
                    word_next.num_lo[i] = {st_word[s].num_lo[i][30:0], take[i]};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg <= 1'b0;
                else if (adv)
                    valid_reg <= st_valid[s];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    word_reg <= word_next;
            end

            assign st_valid[s+1] = valid_reg;
            assign st_word[s+1]  = word_reg;
        end
    endgenerate

    // saturation and sign; output register
    logic             out_valid_reg;
    result_word_t     out_word_reg;
    result_word_t     res_next;
    div_word_t        fin;
    logic [2:0][31:0] limit;
    logic [2:0][31:0] mag;
    logic [2:0][31:0] frc;
    logic [2:0]       clip;

    always_comb
    begin
        fin = st_word[DIV_STAGES];
        for (int i = 0; i < 3; i++)
        begin
            limit[i] = fin.neg[i] ? 32'h7FFF_FFFF : 32'h8000_0000;
            clip[i]  = fin.ovf[i] || (fin.num_lo[i] > limit[i]);
            mag[i]   = clip[i] ? limit[i] : fin.num_lo[i];
            frc[i]   = fin.neg[i] ? mag[i] : (~mag[i] + 32'd1);
        end
        if (fin.kill)
        begin
            res_next = '0;
        end
        else
        begin
            res_next.force_x   = frc[0];
            res_next.force_y   = frc[1];
            res_next.force_z   = frc[2];
            res_next.saturated = |clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= st_valid[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_word_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ rtl/capped_contact_repulsion_force.sv @@
// Capped contact repulsion force, top level.
// From item acceptance to result: square/sum, square root, law and product, divide
// and the output register.
// Throughput one word per cycle; the whole pipeline holds while a result is stalled.
// Reset clears all valid bits and the configuration registers; no clearing pass.
// Depends on ccrf_pkg, ccrf_square, ccrf_sqrt, ccrf_force, ccrf_divide.
module capped_contact_repulsion_force (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ccrf_pkg::item_word_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ccrf_pkg::result_word_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import ccrf_pkg::*;

    logic        adv;
    logic [1:0]  law_reg;
    logic [31:0] stiff_reg;
    logic [30:0] radius_reg;

    logic        sq_valid;
    item_word_t  sq_word;
    logic [63:0] sq_sum;
    logic        rt_valid;
    item_word_t  rt_word;
    logic [31:0] rt_root;
    logic        fc_valid;
    div_word_t   fc_word;

    // pipeline moves unless the output word is held
    assign adv        = !(result_valid && result_stall);
    assign item_stall = !adv;
    assign cfg_ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg    <= LAW_NONE;
            stiff_reg  <= 32'd0;
            radius_reg <= 31'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LAW:    law_reg    <= cfg_data[1:0];
                CFG_STIFF:  stiff_reg  <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    ccrf_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item_valid),
        .in_word   (item),
        .out_valid (sq_valid),
        .out_word  (sq_word),
        .out_sum   (sq_sum)
    );

    ccrf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_word   (sq_word),
        .in_sum    (sq_sum),
        .out_valid (rt_valid),
        .out_word  (rt_word),
        .out_root  (rt_root)
    );

    ccrf_force u_force (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (rt_valid),
        .in_word        (rt_word),
        .in_root        (rt_root),
        .law            (law_reg),
        .stiffness      (stiff_reg),
        .contact_radius (radius_reg),
        .out_valid      (fc_valid),
        .out_word       (fc_word)
    );

    ccrf_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fc_valid),
        .in_word   (fc_word),
        .out_valid (result_valid),
        .out_word  (result)
    );

endmodule

@@ rtl/ccrf_checker.sv @@
// Port-level checks for the capped contact repulsion force block, and its bind.
// Depends on ccrf_pkg.
module ccrf_props (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input ccrf_pkg::result_word_t result,
    input logic                   cfg_ready
);
    import ccrf_pkg::*;

    // a held result stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    // a held result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result word changed while stalled");

    // input back-pressure comes only from a held output word
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("input stalled without output back-pressure");

    // a clipped word carries at least one component at a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.force_x == 32'sh7FFF_FFFF) || (result.force_x == 32'sh8000_0000) ||
            (result.force_y == 32'sh7FFF_FFFF) || (result.force_y == 32'sh8000_0000) ||
            (result.force_z == 32'sh7FFF_FFFF) || (result.force_z == 32'sh8000_0000))
        else $error("saturated flag without a clipped component");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind capped_contact_repulsion_force ccrf_props u_ccrf_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_ready    (cfg_ready)
);
